FILE: hdl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the window sum frame difference unit
// Field widths, register indexes and the control groups passed between the
// position sequencer, the per-frame lanes and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  // pixel and sum widths
  localparam int PIX_W = 8;
  localparam int CUR_W = 10;   // r + g + b of one pixel
  localparam int SUM_W = 17;   // window sum field
  localparam int RUN_W = 18;   // running window sum, also the difference field
  localparam int POS_W = 10;   // window_row / window_col fields

  // row position and height limits
  localparam int ROW_W      = 10;
  localparam int CFG_W      = 11;
  localparam int MAX_HEIGHT = 1024;

  // packed stream widths
  localparam int IN_W  = 6 * PIX_W;
  localparam int OUT_W = 2 * POS_W + 2 * SUM_W + RUN_W;

  // configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // per-item control for the lanes
  typedef struct packed {
    logic first_row;   // row 0: nothing above
    logic old_valid;   // line store holds the row leaving the column sum
    logic row_start;   // column 0: running sum restarts
    logic drop_valid;  // a column leaves the running sum
    logic col_hit;     // column store read collides with the write just made
    logic line_hit;    // line store read collides with the write just made
  } lane_ctl_t;

  // window position and end-of-frame mark for the merge stage
  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } window_info_t;

endpackage

`default_nettype wire

FILE: hdl/window_sum_frame_difference_unit.sv
// ----------------------------------------------------------------------------
// window_sum_frame_difference_unit: sliding window sum comparator, two frames
// Pixel pairs come in raster order on the slave stream; for every square
// window that fits in the image one result leaves on the master stream.
//
// Usage:
//   s_axis: one pixel pair per transfer, both frames' R, G, B bytes.
//   m_axis: one result per window, sent when its bottom-right pixel arrives;
//           tlast marks the final window of the frame pair.
//   cfg:    image_width (index 0) and image_height (index 1), written while
//           no pixels are in flight; widths clamp to 1..MAX_WIDTH, heights
//           to 1..1024.
//   Result path: an accepted pixel is first registered in the update stage;
//   its result loads the output register when that stage completes.
//   Throughput: one pixel per clock while the output is not stalled; each lane
//   forwards its own store write around the registered read of the column
//   and line stores.
//   Reset: positions return to the top-left pixel, the pipeline empties and
//   the size registers return to 640 x 480; the stores are not cleared and
//   need no clearing pass, since row 0 and the first rows never read them.
//   Stall: with a result waiting in the output register, pixels are still
//   taken; s_axis_tready drops only when the update stage also holds a result.
// ----------------------------------------------------------------------------
`default_nettype none

module window_sum_frame_difference_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WINDOW_SIZE = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [wsfd_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [wsfd_pkg::CFG_W-1:0]     cfg_wdata,
  // pixel pairs
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // red_first, green_first, blue_first, red_second, green_second, blue_second
  input  wire logic [wsfd_pkg::IN_W-1:0]      s_axis_tdata,
  // window results
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // window_row, window_col, sum_first, sum_second, sum_difference
  output logic      [wsfd_pkg::OUT_W-1:0]     m_axis_tdata,
  // last_window
  output logic                                m_axis_tlast
);

  localparam int LINES      = WINDOW_SIZE - 1;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int DW         = (CW + 1 > wsfd_pkg::CFG_W) ? CW + 1 : wsfd_pkg::CFG_W;
  localparam int SW         = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int LINE_DEPTH = LINES * (2 ** CW);
  localparam int LAW        = $clog2(LINE_DEPTH);
  localparam int ROW_W      = wsfd_pkg::ROW_W;
  localparam int HW         = wsfd_pkg::CFG_W;
  localparam int POS_W      = wsfd_pkg::POS_W;
  localparam int PIX_W      = wsfd_pkg::PIX_W;

  logic [wsfd_pkg::CFG_W-1:0] image_width;
  logic [wsfd_pkg::CFG_W-1:0] image_height;
  logic [DW-1:0]              width_lim;
  logic [HW-1:0]              height_lim;
  logic [DW-1:0]              cfg_w_ext;
  logic [CW-1:0]              col_pos;
  logic [ROW_W-1:0]           row_pos;
  logic [SW-1:0]              slot;
  logic [DW-1:0]              col_ext;
  logic [HW-1:0]              row_ext;
  logic                       col_end;
  logic                       row_end;
  logic                       accept;
  logic                       fire;
  logic                       merge_ready;
  logic [LAW-1:0]             line_raddr;
  logic [LAW-1:0]             line_waddr;
  wsfd_pkg::lane_ctl_t        ctl_new;
  wsfd_pkg::window_info_t     info_new;
  logic                       emit_new;
  logic                       s1_valid;
  logic                       s1_emit;
  logic [CW-1:0]              s1_col;
  logic [SW-1:0]              s1_slot;
  wsfd_pkg::lane_ctl_t        s1_ctl;
  wsfd_pkg::window_info_t     s1_info;
  logic [wsfd_pkg::RUN_W-1:0] run_first;
  logic [wsfd_pkg::RUN_W-1:0] run_second;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wsfd_pkg::IMAGE_WIDTH_RST;
      image_height <= wsfd_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wsfd_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_wdata;
        end
        wsfd_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // clamped image size
  always_comb begin
    cfg_w_ext = DW'(image_width);
    if (cfg_w_ext == '0) begin
      width_lim = DW'(1);
    end else if (cfg_w_ext > DW'(MAX_WIDTH)) begin
      width_lim = DW'(MAX_WIDTH);
    end else begin
      width_lim = cfg_w_ext;
    end
    if (image_height == '0) begin
      height_lim = HW'(1);
    end else if (image_height > HW'(wsfd_pkg::MAX_HEIGHT)) begin
      height_lim = HW'(wsfd_pkg::MAX_HEIGHT);
    end else begin
      height_lim = image_height;
    end
  end

  // handshake: the update stage completes unless its result has nowhere to go
  assign fire          = s1_valid && (!s1_emit || merge_ready);
  assign s_axis_tready = !s1_valid || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // position decode for the incoming pixel
  always_comb begin
    col_ext  = DW'(col_pos);
    row_ext  = HW'(row_pos);
    col_end  = (col_ext + DW'(1)) >= width_lim;
    row_end  = (row_ext + HW'(1)) >= height_lim;
    emit_new = (row_ext >= HW'(LINES)) && (col_ext >= DW'(LINES)) &&
               (row_ext < height_lim) && (col_ext < width_lim);

    info_new.last = ((row_ext + HW'(1)) == height_lim) &&
                    ((col_ext + DW'(1)) == width_lim);
    info_new.row  = POS_W'(row_ext - HW'(LINES));
    info_new.col  = POS_W'(col_ext - DW'(LINES));

    ctl_new.first_row  = (row_pos == '0);
    ctl_new.old_valid  = row_ext >= HW'(LINES);
    ctl_new.row_start  = (col_pos == '0);
    ctl_new.drop_valid = col_ext >= DW'(WINDOW_SIZE);
    ctl_new.col_hit    = fire && (s1_col == col_pos);
    ctl_new.line_hit   = fire && (s1_col == col_pos) && (s1_slot == slot);
  end

  assign line_raddr = LAW'({slot, col_pos});
  assign line_waddr = LAW'({s1_slot, s1_col});

  // raster position and line store slot
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      slot    <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_pos <= '0;
        if (row_end) begin
          row_pos <= '0;
          slot    <= '0;
        end else begin
          row_pos <= row_pos + ROW_W'(1);
          slot    <= (slot == SW'(LINES - 1)) ? '0 : slot + SW'(1);
        end
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  // update stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit_new;
      s1_col  <= col_pos;
      s1_slot <= slot;
      s1_ctl  <= ctl_new;
      s1_info <= info_new;
    end
  end

  // first frame lane
  wsfd_lane #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIZE (WINDOW_SIZE),
    .LINE_DEPTH  (LINE_DEPTH)
  ) u_lane_first (
    .clk        (clk),
    .load       (accept),
    .red        (s_axis_tdata[0*PIX_W +: PIX_W]),
    .green      (s_axis_tdata[1*PIX_W +: PIX_W]),
    .blue       (s_axis_tdata[2*PIX_W +: PIX_W]),
    .col_raddr  (col_pos),
    .line_raddr (line_raddr),
    .fire       (fire),
    .col_waddr  (s1_col),
    .line_waddr (line_waddr),
    .ctl        (s1_ctl),
    .run_sum    (run_first)
  );

  // second frame lane
  wsfd_lane #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIZE (WINDOW_SIZE),
    .LINE_DEPTH  (LINE_DEPTH)
  ) u_lane_second (
    .clk        (clk),
    .load       (accept),
    .red        (s_axis_tdata[3*PIX_W +: PIX_W]),
    .green      (s_axis_tdata[4*PIX_W +: PIX_W]),
    .blue       (s_axis_tdata[5*PIX_W +: PIX_W]),
    .col_raddr  (col_pos),
    .line_raddr (line_raddr),
    .fire       (fire),
    .col_waddr  (s1_col),
    .line_waddr (line_waddr),
    .ctl        (s1_ctl),
    .run_sum    (run_second)
  );

  // merge and output register
  wsfd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (fire && s1_emit),
    .info          (s1_info),
    .run_first     (run_first),
    .run_second    (run_second),
    .ready         (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: hdl/wsfd_ram.sv
// ----------------------------------------------------------------------------
// wsfd_ram: generic simple dual-port RAM
// One write port, one read port with read enable and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wsfd_lane.sv
// ----------------------------------------------------------------------------
// wsfd_lane: window sum lane for one frame
// Keeps the line store of pixel totals, the column sum store, the recent
// column sums and the running window sum of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_lane #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WINDOW_SIZE = 10,
  parameter int LINE_DEPTH  = 9216
) (
  input  wire logic                                clk,
  // item accepted: capture pixel, start store reads
  input  wire logic                                load,
  input  wire logic [wsfd_pkg::PIX_W-1:0]          red,
  input  wire logic [wsfd_pkg::PIX_W-1:0]          green,
  input  wire logic [wsfd_pkg::PIX_W-1:0]          blue,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        col_raddr,
  input  wire logic [$clog2(LINE_DEPTH)-1:0]       line_raddr,
  // item in the update stage completes
  input  wire logic                                fire,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        col_waddr,
  input  wire logic [$clog2(LINE_DEPTH)-1:0]       line_waddr,
  input  wire wsfd_pkg::lane_ctl_t                 ctl,
  output logic      [wsfd_pkg::RUN_W-1:0]          run_sum
);

  localparam int COL_W = $clog2(WINDOW_SIZE * 765 + 1);
  localparam int CUR_W = wsfd_pkg::CUR_W;
  localparam int RUN_W = wsfd_pkg::RUN_W;

  logic [CUR_W-1:0] cur;
  logic [COL_W-1:0] col_q;
  logic [CUR_W-1:0] line_q;
  logic [COL_W-1:0] fwd_col;
  logic [CUR_W-1:0] fwd_line;
  logic [COL_W-1:0] above;
  logic [CUR_W-1:0] oldest;
  logic [COL_W-1:0] full;
  logic [COL_W-1:0] col_wdata;
  logic [RUN_W-1:0] run;
  logic [RUN_W-1:0] run_base;
  logic [RUN_W-1:0] run_drop;
  logic [COL_W-1:0] taps [WINDOW_SIZE];

  // pixel total captured on transfer
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= CUR_W'(red) + CUR_W'(green) + CUR_W'(blue);
    end
  end

  // column sums of the latest rows, one entry per column
  wsfd_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (load),
    .raddr (col_raddr),
    .rdata (col_q)
  );

  // pixel totals of the rows still inside the column sums
  wsfd_ram #(
    .WIDTH (CUR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (line_waddr),
    .wdata (cur),
    .re    (load),
    .raddr (line_raddr),
    .rdata (line_q)
  );

  // column sum update, with the value written on the previous edge forwarded
  always_comb begin
    if (ctl.first_row) begin
      above = '0;
    end else if (ctl.col_hit) begin
      above = fwd_col;
    end else begin
      above = col_q;
    end
    if (!ctl.old_valid) begin
      oldest = '0;
    end else if (ctl.line_hit) begin
      oldest = fwd_line;
    end else begin
      oldest = line_q;
    end
    full      = above + COL_W'(cur);
    col_wdata = full - COL_W'(oldest);
  end

  // running window sum: add the new column, drop the one leaving
  always_comb begin
    run_base = ctl.row_start ? '0 : run;
    run_drop = ctl.drop_valid ? RUN_W'(taps[WINDOW_SIZE-1]) : '0;
    run_sum  = run_base + RUN_W'(full) - run_drop;
  end

  // state update when the item completes
  always_ff @(posedge clk) begin
    if (fire) begin
      run      <= run_sum;
      fwd_col  <= col_wdata;
      fwd_line <= cur;
      taps[0]  <= full;
      for (int i = 1; i < WINDOW_SIZE; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wsfd_merge.sv
// ----------------------------------------------------------------------------
// wsfd_merge: merge stage and output register
// Combines the two lane sums into one result, forms the difference and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_merge (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire wsfd_pkg::window_info_t         info,
  input  wire logic [wsfd_pkg::RUN_W-1:0]     run_first,
  input  wire logic [wsfd_pkg::RUN_W-1:0]     run_second,
  output logic                                ready,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // window_row, window_col, sum_first, sum_second, sum_difference
  output logic      [wsfd_pkg::OUT_W-1:0]     m_axis_tdata,
  // last_window
  output logic                                m_axis_tlast
);

  localparam int SUM_W = wsfd_pkg::SUM_W;

  logic [wsfd_pkg::RUN_W-1:0] diff;

  assign diff  = run_first - run_second;
  assign ready = !m_axis_tvalid || m_axis_tready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {diff, run_second[SUM_W-1:0], run_first[SUM_W-1:0],
                       info.col, info.row};
      m_axis_tlast <= info.last;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker: port-level checks of the window sum frame difference unit
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [wsfd_pkg::OUT_W-1:0] m_axis_tdata,
  input wire logic                       m_axis_tlast
);

  localparam int SUM_W = wsfd_pkg::SUM_W;
  localparam int RUN_W = wsfd_pkg::RUN_W;
  localparam int SF_LO = 2 * wsfd_pkg::POS_W;
  localparam int SS_LO = SF_LO + SUM_W;
  localparam int DF_LO = SS_LO + SUM_W;

  // a result waiting for the receiver keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output result changed while stalled");

  // the difference matches the two window sums
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[DF_LO +: RUN_W] ==
        RUN_W'(m_axis_tdata[SF_LO +: SUM_W]) - RUN_W'(m_axis_tdata[SS_LO +: SUM_W]))
    else $error("sum difference does not match the window sums");

  // input side stalls only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind window_sum_frame_difference_unit wsfd_checker u_wsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: test/window_sum_frame_difference_unit_tb.sv
// ----------------------------------------------------------------------------
// window_sum_frame_difference_unit_tb: self-checking bench for the window sum unit
// Streams pixel pairs in raster order under several frame sizes (default,
// clamped, degenerate, full scale and small random frames, some resized in
// the middle of a frame), predicts every window result from its own model of
// the line, column and running sums, and checks each result on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module window_sum_frame_difference_unit_tb;

  localparam int POS_W       = wsfd_pkg::POS_W;
  localparam int SUM_W       = wsfd_pkg::SUM_W;
  localparam int RUN_W       = wsfd_pkg::RUN_W;
  localparam int IN_W        = wsfd_pkg::IN_W;
  localparam int OUT_W       = wsfd_pkg::OUT_W;
  localparam int CFG_AW      = wsfd_pkg::CFG_AW;
  localparam int CFG_W       = wsfd_pkg::CFG_W;
  localparam int MAX_HEIGHT  = wsfd_pkg::MAX_HEIGHT;
  localparam int MAX_W       = 1024;
  localparam int WIN         = 10;
  localparam int LINES       = WIN - 1;
  localparam int CYCLE_LIMIT = 1000000;

  // one window result, field by field
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [SUM_W-1:0] sum_first;
    logic [SUM_W-1:0] sum_second;
    logic [RUN_W-1:0] sum_diff;
    logic             last;
  } window_result_t;

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_DARK, PIX_FIRST_FULL, PIX_SECOND_FULL}
    pix_mode_t;

  // box sum predictor and result store
  class window_scoreboard;
    int unsigned    width_reg;
    int unsigned    height_reg;
    int unsigned    cur_row;
    int unsigned    cur_col;
    int unsigned    row_hist [LINES][MAX_W][2];
    int unsigned    col_sums [MAX_W][2];
    int unsigned    recent_cols [WIN][2];
    int unsigned    box_sum [2];
    window_result_t pending_windows [$];
    int             errors;
    int             windows_seen;

    function new();
      width_reg    = 32'(wsfd_pkg::IMAGE_WIDTH_RST);
      height_reg   = 32'(wsfd_pkg::IMAGE_HEIGHT_RST);
      cur_row      = 0;
      cur_col      = 0;
      errors       = 0;
      windows_seen = 0;
    endfunction

    function int unsigned eff_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_size(int unsigned w, int unsigned h);
      width_reg  = w & 'h7FF;
      height_reg = h & 'h7FF;
    endfunction

    function bit at_frame_start();
      return cur_row == 0 && cur_col == 0;
    endfunction

    function int pending();
      return pending_windows.size();
    endfunction

    // advance the raster position by one accepted pixel pair
    function void take_pixel(logic [IN_W-1:0] px);
      int unsigned    w, h, r, c, slot, slot_col;
      int unsigned    cur [2];
      int unsigned    above, full, oldest, run;
      int             f;
      window_result_t res;
      w        = eff_dim(width_reg, MAX_W);
      h        = eff_dim(height_reg, MAX_HEIGHT);
      r        = cur_row;
      c        = cur_col % MAX_W;
      slot     = r % LINES;
      slot_col = cur_col % WIN;
      cur[0]   = 32'(px[7:0]) + 32'(px[15:8]) + 32'(px[23:16]);
      cur[1]   = 32'(px[31:24]) + 32'(px[39:32]) + 32'(px[47:40]);
      for (f = 0; f < 2; f++) begin
        // vertical sum over the latest rows, then the horizontal run
        above  = (r == 0) ? 0 : col_sums[c][f];
        full   = above + cur[f];
        oldest = (r >= LINES) ? row_hist[slot][c][f] : 0;
        run    = (cur_col == 0) ? 0 : box_sum[f];
        col_sums[c][f]       = full - oldest;
        row_hist[slot][c][f] = cur[f];
        run += full;
        if (cur_col >= WIN) run -= recent_cols[slot_col][f];
        recent_cols[slot_col][f] = full;
        box_sum[f] = run;
      end
      // bottom-right pixel of a window inside the image
      if (r >= LINES && cur_col >= LINES && r < h && cur_col < w) begin
        res.row        = POS_W'(r - LINES);
        res.col        = POS_W'(cur_col - LINES);
        res.sum_first  = SUM_W'(box_sum[0]);
        res.sum_second = SUM_W'(box_sum[1]);
        res.sum_diff   = RUN_W'(box_sum[0] - box_sum[1]);
        res.last       = (r + 1 == h && cur_col + 1 == w);
        pending_windows.push_back(res);
      end
      if (cur_col + 1 >= w) begin
        cur_col = 0;
        cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        cur_col++;
      end
    endfunction

    // compare one output transfer against the oldest prediction
    function void check_window(logic [OUT_W-1:0] data, logic last);
      window_result_t want, got;
      got.row        = data[POS_W-1:0];
      got.col        = data[2*POS_W-1:POS_W];
      got.sum_first  = data[2*POS_W+SUM_W-1:2*POS_W];
      got.sum_second = data[2*POS_W+2*SUM_W-1:2*POS_W+SUM_W];
      got.sum_diff   = data[OUT_W-1:2*POS_W+2*SUM_W];
      got.last       = last;
      windows_seen++;
      if (pending_windows.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected window result: row %0d col %0d", got.row, got.col);
        return;
      end
      want = pending_windows.pop_front();
      if (got.row != want.row || got.col != want.col || got.sum_first != want.sum_first ||
          got.sum_second != want.sum_second || got.sum_diff != want.sum_diff ||
          got.last != want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("window mismatch: expected row %0d col %0d sums %0d/%0d diff %0d last %0b",
                   want.row, want.col, want.sum_first, want.sum_second,
                   $signed(want.sum_diff), want.last);
          $display("                 actual   row %0d col %0d sums %0d/%0d diff %0d last %0b",
                   got.row, got.col, got.sum_first, got.sum_second,
                   $signed(got.sum_diff), got.last);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst           = 1'b1;
  logic                cfg_we        = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr      = wsfd_pkg::REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]    cfg_wdata     = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  window_scoreboard    sb = new();
  int unsigned         cycle_count  = 0;
  int unsigned         stall_tick   = 0;
  int unsigned         burst_left   = 0;
  int unsigned         pixel_count  = 0;
  int unsigned         size_changes = 0;

  window_sum_frame_difference_unit #(
    .MAX_WIDTH   (MAX_W),
    .WINDOW_SIZE (WIN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("window_sum_frame_difference_unit_tb: FAIL");
      $finish;
    end
  end

  // result side: check each transfer, stall on a rotating pattern
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_window(m_axis_tdata, m_axis_tlast);
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 300) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (stall_tick % 5 == 0);
      default: m_axis_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // pixel pair content for one frame style
  function automatic logic [IN_W-1:0] make_pixel(pix_mode_t fill);
    logic [63:0]     raw;
    logic [IN_W-1:0] v;
    v = '0;
    case (fill)
      PIX_RANDOM: begin
        raw = {$urandom, $urandom};
        v   = raw[IN_W-1:0];
      end
      PIX_EXTREME: begin
        for (int k = 0; k < 6; k++) v[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PIX_DARK: begin
        for (int k = 0; k < 6; k++) v[8*k +: 8] = 8'($urandom_range(0, 7));
      end
      PIX_FIRST_FULL:  v = 48'h000000_FFFFFF;
      PIX_SECOND_FULL: v = 48'hFFFFFF_000000;
      default:         v = '0;
    endcase
    return v;
  endfunction

  // one input transfer, with bursts and random gaps in between
  task push_pixel(input logic [IN_W-1:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tdata  <= px;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.take_pixel(px);
    pixel_count++;
  endtask

  // hold off until every predicted window has come out, then let the pipe empty
  task settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both size registers, back to back
  task set_frame_size(input int unsigned w, input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_addr  <= wsfd_pkg::REG_IMAGE_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_addr  <= wsfd_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_size(w, h);
    size_changes++;
    @(posedge clk);
  endtask

  task finish_frame(input pix_mode_t fill);
    while (!sb.at_frame_start()) push_pixel(make_pixel(fill));
  endtask

  // stimulus
  initial begin
    int unsigned w, h, w2, h2, n, rand_start;
    pix_mode_t   fill;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner pixels at the top-left of the default 640 x 480 frame
    for (int k = 0; k < 6; k++) push_pixel(48'hFF << (8 * k));
    push_pixel(48'h0);
    push_pixel({IN_W{1'b1}});
    push_pixel(48'h000000_FFFFFF);
    push_pixel(48'hFFFFFF_000000);
    push_pixel(48'hAAAAAA_AAAAAA);
    push_pixel(48'h555555_555555);
    repeat (8) push_pixel(make_pixel(PIX_RANDOM));
    settle();

    // shrink mid-frame: row ends at once, the rest of the frame is narrow
    set_frame_size(12, 10);
    finish_frame(PIX_RANDOM);
    settle();

    // full-scale sums, both signs of the difference
    set_frame_size(10, 10);
    repeat (100) push_pixel(make_pixel(PIX_FIRST_FULL));
    repeat (100) push_pixel(make_pixel(PIX_SECOND_FULL));
    settle();

    // largest width setting (clamped), then a narrower line mid-row
    set_frame_size(2047, 10);
    repeat (40) push_pixel(make_pixel(PIX_EXTREME));
    settle();
    set_frame_size(20, 10);
    finish_frame(PIX_RANDOM);
    settle();

    // degenerate sizes: no windows at all
    set_frame_size(0, 0);
    repeat (16) push_pixel(make_pixel(PIX_RANDOM));
    settle();
    set_frame_size(9, 12);
    repeat (108) push_pixel(make_pixel(PIX_RANDOM));
    settle();
    set_frame_size(12, 9);
    repeat (108) push_pixel(make_pixel(PIX_RANDOM));

    // random small frames, some resized part way through
    rand_start = pixel_count;
    while (pixel_count - rand_start < 570) begin
      settle();
      w    = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 40) : $urandom_range(10, 24);
      h    = $urandom_range(10, 16);
      fill = pix_mode_t'($urandom_range(0, 2));
      set_frame_size(w, h);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, w * h - 1);
        repeat (n) push_pixel(make_pixel(fill));
        settle();
        // width may only shrink here, height goes either way
        w2 = $urandom_range(0, w);
        h2 = $urandom_range(0, 20);
        set_frame_size(w2, h2);
        finish_frame(fill);
      end else begin
        repeat (w * h) begin
          push_pixel(make_pixel(fill));
          if ($urandom_range(0, 199) == 0) settle();
        end
      end
    end

    // drain and wrap up
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0d expected windows never arrived", sb.pending());
    end
    $display("covered %0d pixel pairs under %0d frame size settings, %0d windows checked",
             pixel_count, size_changes, sb.windows_seen);
    $display("included clamped and degenerate sizes, mid-frame resizing and full-scale sums");
    if (sb.errors == 0) begin
      $display("window_sum_frame_difference_unit_tb: PASS");
    end else begin
      $display("window_sum_frame_difference_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/wsfd_pkg.sv
hdl/wsfd_ram.sv
hdl/wsfd_lane.sv
hdl/wsfd_merge.sv
hdl/window_sum_frame_difference_unit.sv
hdl/wsfd_checker.sv
test/window_sum_frame_difference_unit_tb.sv
